// ===== hw/rtl/asgd_pkg.sv =====
// ----------------------------------------------------------------------------
// asgd_pkg: shared types and constants of the weight-update engine
// Holds the sequencer step codes, the command and status bundles that join
// the controller and the datapath, the configuration bundle and reset values.
// ----------------------------------------------------------------------------
package asgd_pkg;

    // Sequencer steps; the controller state is also the datapath command.
    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_READ  = 5'd2;
    localparam logic [4:0] S_DISP  = 5'd3;
    localparam logic [4:0] S_CLRW  = 5'd4;
    localparam logic [4:0] S_G_MUL = 5'd5;
    localparam logic [4:0] S_G_APP = 5'd6;
    localparam logic [4:0] S_P1    = 5'd7;
    localparam logic [4:0] S_P2    = 5'd8;
    localparam logic [4:0] S_P3    = 5'd9;
    localparam logic [4:0] S_P4    = 5'd10;
    localparam logic [4:0] S_SQ1   = 5'd11;
    localparam logic [4:0] S_P5    = 5'd12;
    localparam logic [4:0] S_P6    = 5'd13;
    localparam logic [4:0] S_DV1   = 5'd14;
    localparam logic [4:0] S_P7    = 5'd15;
    localparam logic [4:0] S_M1    = 5'd16;
    localparam logic [4:0] S_M2    = 5'd17;
    localparam logic [4:0] S_M3    = 5'd18;
    localparam logic [4:0] S_V1    = 5'd19;
    localparam logic [4:0] S_V2    = 5'd20;
    localparam logic [4:0] S_V3    = 5'd21;
    localparam logic [4:0] S_V4    = 5'd22;
    localparam logic [4:0] S_V5    = 5'd23;
    localparam logic [4:0] S_V6    = 5'd24;
    localparam logic [4:0] S_SQ2   = 5'd25;
    localparam logic [4:0] S_D1    = 5'd26;
    localparam logic [4:0] S_D2    = 5'd27;
    localparam logic [4:0] S_D3    = 5'd28;
    localparam logic [4:0] S_DV2   = 5'd29;
    localparam logic [4:0] S_D4    = 5'd30;
    localparam logic [4:0] S_FIN   = 5'd31;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_LR   = 3'd1;
    localparam logic [2:0] REG_B1   = 3'd2;
    localparam logic [2:0] REG_B2   = 3'd3;
    localparam logic [2:0] REG_EPS  = 3'd4;

    // Register reset values.
    localparam logic        MODE_RST = 1'b1;
    localparam logic [31:0] LR_RST   = 32'd4294967;
    localparam logic [31:0] B1_RST   = 32'd3865470566;
    localparam logic [31:0] B2_RST   = 32'd4290672329;
    localparam logic [23:0] EPS_RST  = 24'd10995;

    localparam logic [39:0] RATE_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;

    typedef struct packed {
        logic        mode;
        logic [31:0] base_rate;
        logic [31:0] beta_one;
        logic [31:0] beta_two;
        logic [23:0] epsilon;
    } cfg_t;

    typedef struct packed {
        logic [4:0] step;
        logic       accept;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic is_clear;
        logic new_pass;
        logic mode;
        logic om1_zero;
        logic sqrt_done;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

// ===== hw/rtl/asgd_ram.sv =====
// ----------------------------------------------------------------------------
// asgd_ram: generic simple dual-port RAM
// One write port and one read port with a registered read that updates only
// when a read is enabled.
// ----------------------------------------------------------------------------
module asgd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== hw/rtl/asgd_sqrt.sv =====
// ----------------------------------------------------------------------------
// asgd_sqrt: iterative floor square root
// Takes a 64-bit radicand and produces a 32-bit root, one bit per cycle.
// ----------------------------------------------------------------------------
module asgd_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] x,
    output logic        done,
    output logic [31:0] root
);
    logic [63:0] x_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;

    assign rem_sh = {rem_reg, x_reg[63:62]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign diff   = rem_sh - trial;
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= x;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            x_reg    <= {x_reg[61:0], 2'b00};
            rem_reg  <= ge ? diff[33:0] : rem_sh[33:0];
            root_reg <= {root_reg[30:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

// ===== hw/rtl/asgd_div.sv =====
// ----------------------------------------------------------------------------
// asgd_div: iterative restoring divider
// Divides an 80-bit dividend by a 49-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module asgd_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [79:0] dividend,
    input  logic [48:0] divisor,
    output logic        done,
    output logic [79:0] quot,
    output logic [48:0] rem
);
    logic [79:0] q_reg;
    logic [48:0] rem_reg;
    logic [48:0] d_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [49:0] rem_sh;
    logic [49:0] diff;
    logic        ge;

    assign rem_sh = {rem_reg, q_reg[79]};
    assign diff   = rem_sh - {1'b0, d_reg};
    assign ge     = (rem_sh >= {1'b0, d_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd79) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[78:0], ge};
            rem_reg <= ge ? diff[48:0] : rem_sh[48:0];
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = rem_reg;
endmodule

// ===== hw/rtl/asgd_ctrl.sv =====
// ----------------------------------------------------------------------------
// asgd_ctrl: sequencer of the weight-update engine
// Walks one request through the steps of its mode and tells the datapath
// which step to perform.
// ----------------------------------------------------------------------------
module asgd_ctrl
    import asgd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);
    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (sts.clr_done) state_next = S_IDLE;
            S_IDLE:  if (s_tvalid) state_next = S_READ;
            S_READ:  state_next = S_DISP;
            S_DISP: begin
                if (sts.is_clear)      state_next = S_CLRW;
                else if (!sts.mode)    state_next = S_G_MUL;
                else if (sts.new_pass) state_next = S_P1;
                else                   state_next = S_M1;
            end
            S_CLRW:  state_next = S_FIN;
            S_G_MUL: state_next = S_G_APP;
            S_G_APP: state_next = S_FIN;
            S_P1:    state_next = S_P2;
            S_P2:    state_next = S_P3;
            S_P3:    state_next = S_P4;
            S_P4:    state_next = S_SQ1;
            S_SQ1:   if (sts.sqrt_done) state_next = S_P5;
            S_P5:    state_next = S_P6;
            S_P6:    state_next = sts.om1_zero ? S_M1 : S_DV1;
            S_DV1:   if (sts.div_done) state_next = S_P7;
            S_P7:    state_next = S_M1;
            S_M1:    state_next = S_M2;
            S_M2:    state_next = S_M3;
            S_M3:    state_next = S_V1;
            S_V1:    state_next = S_V2;
            S_V2:    state_next = S_V3;
            S_V3:    state_next = S_V4;
            S_V4:    state_next = S_V5;
            S_V5:    state_next = S_V6;
            S_V6:    state_next = S_SQ2;
            S_SQ2:   if (sts.sqrt_done) state_next = S_D1;
            S_D1:    state_next = S_D2;
            S_D2:    state_next = S_D3;
            S_D3:    state_next = S_DV2;
            S_DV2:   if (sts.div_done) state_next = S_D4;
            S_D4:    state_next = S_FIN;
            S_FIN:   if (sts.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready     = (state_reg == S_IDLE);
    assign cmd.step     = state_reg;
    assign cmd.accept   = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.out_load = (state_reg == S_FIN) && sts.out_free;

    // Only one request is in flight: ready drops right after an accept.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request accepted while one is in flight");

    // A finished result waits as long as the output register is full and not being taken.
    a_fin_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && !sts.out_free) |=> (state_reg == S_FIN))
        else $error("result step left while output register busy");

    // A step that waits on the square root leaves exactly when it finishes.
    a_sqrt_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SQ2 && sts.sqrt_done) |=> (state_reg == S_D1))
        else $error("square root wait did not advance");
endmodule

// ===== hw/rtl/asgd_dp.sv =====
// ----------------------------------------------------------------------------
// asgd_dp: datapath of the weight-update engine
// Moment stores, step powers, corrected rate, one shared 32x32 multiplier,
// an iterative square root, an iterative divider and the output register.
// ----------------------------------------------------------------------------
module asgd_dp
    import asgd_pkg::*;
#(
    parameter int TENSOR_SLOTS        = 8,
    parameter int ELEMENTS_PER_TENSOR = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic        in_cmd,
    input  logic        in_new_pass,
    input  logic [2:0]  in_slot,
    input  logic [9:0]  in_elem,
    input  logic [31:0] in_grad,
    input  logic [31:0] in_param,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] out_param,
    output logic        out_sat
);
    localparam int DEPTH = TENSOR_SLOTS * ELEMENTS_PER_TENSOR;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [16:0]   SLOT_N    = 17'(TENSOR_SLOTS);
    localparam logic [16:0]   ELEM_N    = 17'(ELEMENTS_PER_TENSOR);

    // x mod n for a 10-bit x by restoring subtraction of shifted n.
    function automatic logic [9:0] reduce10(input logic [9:0] x, input logic [16:0] n);
        logic [25:0] r;
        r = {16'b0, x};
        for (int k = 9; k >= 0; k--) begin
            if (r >= ({9'b0, n} << k)) begin
                r = r - ({9'b0, n} << k);
            end
        end
        return r[9:0];
    endfunction

    // p minus a signed magnitude, clipped to signed 32 bits; bit 32 flags a clip.
    function automatic logic [32:0] apply_delta(input logic [31:0] p, input logic neg,
                                                input logic [41:0] mag);
        logic signed [43:0] ps;
        logic signed [43:0] ms;
        logic signed [43:0] r;
        ps = 44'($signed(p));
        ms = $signed({2'b00, mag});
        r  = neg ? (ps + ms) : (ps - ms);
        if (r > 44'sd2147483647) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (r < -44'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, r[31:0]};
    endfunction

    logic             cmd_reg;
    logic             np_reg;
    logic [31:0]      g_reg;
    logic [31:0]      p_reg;
    logic [AW-1:0]    addr_reg;
    logic [AW-1:0]    clr_cnt_reg;
    logic [32:0]      b1p_reg;
    logic [32:0]      b2p_reg;
    logic [39:0]      rate_reg;
    logic [79:0]      acc_reg;
    logic [63:0]      sq_reg;
    logic [63:0]      v_new_reg;
    logic [33:0]      m_new_reg;
    logic [48:0]      den_reg;
    logic             sat_reg;
    logic [31:0]      res_reg;
    logic [63:0]      prod_reg;
    logic             m_valid_reg;
    logic [31:0]      m_data_reg;
    logic             m_sat_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] m_rd;
    logic [63:0] v_rd;
    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0] m_wdata;
    logic [63:0] v_wdata;

    logic [9:0]  slot_m;
    logic [9:0]  elem_m;
    logic [31:0] addr_full;

    logic [31:0] mu;
    logic [31:0] gu;
    logic [31:0] gm;
    logic [32:0] ob1;
    logic [32:0] ob2;
    logic [32:0] om1;
    logic [32:0] om2;
    logic        root_full;
    logic [63:0] num;
    logic [64:0] sum_m;
    logic [64:0] rnd_m;
    logic [33:0] m_val;
    logic [33:0] neg_m;
    logic [31:0] mag_m;
    logic [63:0] v_sum;
    logic [48:0] den_raw;
    logic [71:0] n_sum;
    logic [64:0] d_full;
    logic        q_over;
    logic        q_round;
    logic [41:0] q_fin;
    logic [32:0] app_g;
    logic [32:0] app_a;

    logic        sq_start;
    logic [63:0] sq_x;
    logic        sq_done;
    logic [31:0] sq_root;
    logic        dv_start;
    logic [79:0] dv_num;
    logic [48:0] dv_den;
    logic        dv_done;
    logic [79:0] dv_quot;
    logic [48:0] dv_rem;

    // Element address: slot and index reduced to the configured store shape.
    assign slot_m    = reduce10({7'b0, in_slot}, SLOT_N);
    assign elem_m    = reduce10(in_elem, ELEM_N);
    assign addr_full = 32'(slot_m) * 32'(ELEMENTS_PER_TENSOR) + 32'(elem_m);

    assign mu   = m_rd ^ 32'h8000_0000;
    assign gu   = g_reg ^ 32'h8000_0000;
    assign gm   = g_reg[31] ? (~g_reg + 32'd1) : g_reg;
    assign ob1  = ONE_Q32 - {1'b0, cfg.beta_one};
    assign ob2  = ONE_Q32 - {1'b0, cfg.beta_two};
    assign om1  = ONE_Q32 - b1p_reg;
    assign om2  = ONE_Q32 - b2p_reg;
    assign root_full = (b2p_reg == 33'd0);
    assign num  = root_full ? {cfg.base_rate, 32'b0} : prod_reg;

    assign sum_m = {1'b0, acc_reg[63:0]} + {1'b0, prod_reg}
                 + (ob1[32] ? {1'b0, gu, 32'b0} : 65'd0);
    assign rnd_m = sum_m + 65'h8000_0000;
    assign m_val = {1'b0, rnd_m[64:32]} - 34'h0_8000_0000;
    assign neg_m = ~m_new_reg + 34'd1;
    assign mag_m = m_new_reg[33] ? neg_m[31:0] : m_new_reg[31:0];

    assign v_sum   = acc_reg[63:0] + (ob2[32] ? sq_reg : {32'b0, prod_reg[63:32]});
    assign den_raw = {1'b0, sq_root, 16'b0} + {25'b0, cfg.epsilon};
    assign n_sum   = {8'b0, acc_reg[63:0]} + {prod_reg[39:0], 32'b0};

    assign d_full  = {1'b0, prod_reg} + 65'h8000_0000;
    assign q_over  = |dv_quot[79:41];
    assign q_round = ({dv_rem, 1'b0} >= {1'b0, den_reg});
    assign q_fin   = q_over ? 42'h100_0000_0000 : (dv_quot[41:0] + {41'b0, q_round});
    assign app_g   = apply_delta(p_reg, g_reg[31], {9'b0, d_full[64:32]});
    assign app_a   = apply_delta(p_reg, m_new_reg[33], q_fin);

    // Operand selection of the shared multiplier; product is ready next step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.step)
            S_G_MUL: begin mul_a = cfg.base_rate; mul_b = gm; end
            S_P1:    begin mul_a = b1p_reg[31:0]; mul_b = cfg.beta_one; end
            S_P2:    begin mul_a = b2p_reg[31:0]; mul_b = cfg.beta_two; end
            S_P5:    begin mul_a = cfg.base_rate; mul_b = sq_root; end
            S_M1:    begin mul_a = mu; mul_b = cfg.beta_one; end
            S_M2:    begin mul_a = gu; mul_b = ob1[31:0]; end
            S_M3:    begin mul_a = v_rd[63:32]; mul_b = cfg.beta_two; end
            S_V1:    begin mul_a = v_rd[31:0]; mul_b = cfg.beta_two; end
            S_V2:    begin mul_a = gm; mul_b = gm; end
            S_V3:    begin mul_a = prod_reg[63:32]; mul_b = ob2[31:0]; end
            S_V4:    begin mul_a = sq_reg[31:0]; mul_b = ob2[31:0]; end
            S_D1:    begin mul_a = rate_reg[31:0]; mul_b = mag_m; end
            S_D2:    begin mul_a = {24'b0, rate_reg[39:32]}; mul_b = mag_m; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    // Store writes: clearing pass, clear command and the moment write-back.
    assign ram_we    = (cmd.step == S_CLEAR) || (cmd.step == S_CLRW) || (cmd.step == S_V6);
    assign ram_waddr = (cmd.step == S_CLEAR) ? clr_cnt_reg : addr_reg;
    assign m_wdata   = (cmd.step == S_V6) ? m_new_reg[31:0] : 32'd0;
    assign v_wdata   = (cmd.step == S_V6) ? v_new_reg : 64'd0;

    asgd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_m_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (m_wdata),
        .re    (cmd.step == S_READ),
        .raddr (addr_reg),
        .rdata (m_rd)
    );

    asgd_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_v_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (v_wdata),
        .re    (cmd.step == S_READ),
        .raddr (addr_reg),
        .rdata (v_rd)
    );

    assign sq_start = (cmd.step == S_P4) || (cmd.step == S_V6);
    assign sq_x     = (cmd.step == S_P4) ? {om2[31:0], 32'b0} : v_new_reg;

    asgd_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .x       (sq_x),
        .done    (sq_done),
        .root    (sq_root)
    );

    assign dv_start = ((cmd.step == S_P6) && (om1 != 33'd0)) || (cmd.step == S_D3);
    assign dv_num   = (cmd.step == S_P6) ? {16'b0, num} : {n_sum, 8'b0};
    assign dv_den   = (cmd.step == S_P6) ? {16'b0, om1} : den_reg;

    asgd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (dv_start),
        .dividend (dv_num),
        .divisor  (dv_den),
        .done     (dv_done),
        .quot     (dv_quot),
        .rem      (dv_rem)
    );

    // Control state: clearing counter, step powers, rate and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            b1p_reg     <= ONE_Q32;
            b2p_reg     <= ONE_Q32;
            rate_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.step == S_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.step == S_P2) begin
                b1p_reg <= (b1p_reg[32] ? {1'b0, cfg.beta_one} : 33'd0)
                         + {1'b0, prod_reg[63:32]};
            end
            if (cmd.step == S_P3) begin
                b2p_reg <= (b2p_reg[32] ? {1'b0, cfg.beta_two} : 33'd0)
                         + {1'b0, prod_reg[63:32]};
            end
            if ((cmd.step == S_P6) && (om1 == 33'd0)) begin
                rate_reg <= RATE_MAX;
            end
            if (cmd.step == S_P7) begin
                rate_reg <= (|dv_quot[79:40]) ? RATE_MAX : dv_quot[39:0];
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cmd_reg  <= in_cmd;
            np_reg   <= in_new_pass;
            g_reg    <= in_grad;
            p_reg    <= in_param;
            addr_reg <= AW'(addr_full);
            sat_reg  <= 1'b0;
        end
        case (cmd.step)
            S_CLRW: res_reg <= p_reg;
            S_G_APP: begin
                res_reg <= app_g[31:0];
                sat_reg <= sat_reg | app_g[32];
            end
            S_P6: if (om1 == 33'd0) sat_reg <= 1'b1;
            S_P7: if (|dv_quot[79:40]) sat_reg <= 1'b1;
            S_M2: acc_reg <= {16'b0, prod_reg};
            S_M3: m_new_reg <= m_val;
            S_V1: acc_reg <= {16'b0, prod_reg};
            S_V2: acc_reg <= acc_reg + {48'b0, prod_reg[63:32]};
            S_V3: sq_reg <= prod_reg;
            S_V4: if (!ob2[32]) acc_reg <= acc_reg + {16'b0, prod_reg};
            S_V5: v_new_reg <= v_sum;
            S_D1: den_reg <= (den_raw == 49'd0) ? 49'd1 : den_raw;
            S_D2: acc_reg <= {16'b0, prod_reg};
            S_D4: begin
                res_reg <= app_a[31:0];
                sat_reg <= sat_reg | app_a[32];
            end
            default: ;
        endcase
        if (cmd.out_load) begin
            m_data_reg <= res_reg;
            m_sat_reg  <= sat_reg;
        end
    end

    assign sts.clr_done  = (clr_cnt_reg == LAST_ADDR);
    assign sts.is_clear  = cmd_reg;
    assign sts.new_pass  = np_reg;
    assign sts.mode      = cfg.mode;
    assign sts.om1_zero  = (om1 == 33'd0);
    assign sts.sqrt_done = sq_done;
    assign sts.div_done  = dv_done;
    assign sts.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid  = m_valid_reg;
    assign out_param = m_data_reg;
    assign out_sat   = m_sat_reg;
endmodule

// ===== hw/rtl/adam_sgd_weight_update_top.sv =====
// ----------------------------------------------------------------------------
// adam_sgd_weight_update_top: streaming SGD / Adam weight-update engine
// Each request runs the steps of its kind: a clear, gradient descent, or Adam
// with a square root and a divide; an Adam element that opens a pass first
// recomputes the step powers and the corrected rate, skipping the rate divide
// when the rate clips. Throughput: one request at a time; s_tready returns in
// the cycle after the result loads, and a result waits while the output is full.
// Reset: a clearing pass zeroes every moment entry, one per cycle, before the
// first request is taken.
// ----------------------------------------------------------------------------
module adam_sgd_weight_update_top
    import asgd_pkg::*;
#(
    parameter int TENSOR_SLOTS        = 8,
    parameter int ELEMENTS_PER_TENSOR = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input requests.
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata fields from bit 0: tensor_slot[2:0], element_index[12:3],
    // grad_value[44:13], param_value[76:45], zero fill [79:77].
    input  logic [79:0] s_tdata,
    // tuser fields from bit 0: cmd[0], new_pass[1].
    input  logic [1:0]  s_tuser,
    // Result requests.
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata fields from bit 0: updated_param[31:0].
    output logic [31:0] m_tdata,
    // tuser fields from bit 0: saturated[0].
    output logic [0:0]  m_tuser
);
    cfg_t       cfg_reg;
    cmd_t       cmd;
    sts_t       sts;
    logic [2:0] reg_idx;
    logic       cfg_write;

    // Registers sit at byte address four times their index; a write lands on
    // the access cycle. pready is tied high, so no wait states are inserted.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode      <= MODE_RST;
            cfg_reg.base_rate <= LR_RST;
            cfg_reg.beta_one  <= B1_RST;
            cfg_reg.beta_two  <= B2_RST;
            cfg_reg.epsilon   <= EPS_RST;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_MODE: cfg_reg.mode      <= pwdata[0];
                REG_LR:   cfg_reg.base_rate <= pwdata;
                REG_B1:   cfg_reg.beta_one  <= pwdata;
                REG_B2:   cfg_reg.beta_two  <= pwdata;
                REG_EPS:  cfg_reg.epsilon   <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // Read-back of the register selected by the address; other addresses read zero.
    always_comb begin
        unique case (reg_idx)
            REG_MODE: prdata = {31'b0, cfg_reg.mode};
            REG_LR:   prdata = cfg_reg.base_rate;
            REG_B1:   prdata = cfg_reg.beta_one;
            REG_B2:   prdata = cfg_reg.beta_two;
            REG_EPS:  prdata = {8'b0, cfg_reg.epsilon};
            default:  prdata = 32'd0;
        endcase
    end

    // The sequencer owns the input handshake and steps the datapath.
    asgd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the moment stores, the arithmetic and the output register.
    asgd_dp #(
        .TENSOR_SLOTS        (TENSOR_SLOTS),
        .ELEMENTS_PER_TENSOR (ELEMENTS_PER_TENSOR)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .cmd         (cmd),
        .sts         (sts),
        .in_cmd      (s_tuser[0]),
        .in_new_pass (s_tuser[1]),
        .in_slot     (s_tdata[2:0]),
        .in_elem     (s_tdata[12:3]),
        .in_grad     (s_tdata[44:13]),
        .in_param    (s_tdata[76:45]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_param   (m_tdata),
        .out_sat     (m_tuser[0])
    );
endmodule
